@@ rtl/core/multigroup_isotropic_source_unit_assert.svh @@
// assertion macros shared by the isotropic source unit
`ifndef MULTIGROUP_ISOTROPIC_SOURCE_UNIT_ASSERT_SVH
`define MULTIGROUP_ISOTROPIC_SOURCE_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MISU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define MISU_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/misu_pkg.sv @@
// shared types, constants and helpers of the isotropic source unit
package misu_pkg;

   localparam int DATA_W = 32;
   localparam int ACC_W  = 64;

   // 1/(4 pi) as unsigned Q0.32, rounded to nearest
   localparam logic [DATA_W-1:0] INV_FOUR_PI_Q32 = 32'd341782638;

   typedef struct packed {
      logic [ACC_W-1:0]  scatter_sum;
      logic [ACC_W-1:0]  fission_sum;
      logic [DATA_W-1:0] fission_spectrum;
      logic [DATA_W-1:0] total_xs;
   } misu_job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHI,
      ST_FIS,
      ST_SUM,
      ST_SCALE,
      ST_CHECK,
      ST_DIV,
      ST_DONE
   } misu_state_type;

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                input logic [ACC_W-1:0] b);
      logic [ACC_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
   endfunction

endpackage

@@ rtl/core/multigroup_isotropic_source_unit.sv @@
// top level of the multigroup isotropic source unit
// Requests stream in on req_*, one outgoing energy group per request, and may
// arrive every cycle; the front accumulates scatter and fission dot products.
// The request with req_tlast set closes the target group: its sums, chi and
// total cross section go through a small job queue to the finishing unit,
// which returns one result on rsp_* (source in rsp_tdata, divide error flag in
// rsp_tuser). csr_* writes the inverse eigenvalue and is always ready.
// The finishing unit handles one group at a time with its shared 32x32
// multiplier (two 64-bit products) and the radix-2 divider (32 steps), which
// zero or overflowing totals skip; the queue lets the front keep streaming
// while it works. If the queue fills, req_tready drops on a closing request
// until room appears. When rsp_tready is low the result waits in the output
// register and the finishing unit holds its next result. Reset clears the
// sums, the queue and the output valid and sets the inverse eigenvalue to
// 1.0; the unit takes requests right after.
`include "multigroup_isotropic_source_unit_assert.svh"

module multigroup_isotropic_source_unit
   import misu_pkg::*;
#(
   parameter int FRAC_BITS   = 24,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // scatter_xs, fission_xs, group_flux, fission_spectrum, total_xs
   input  logic [5*DATA_W-1:0] req_tdata,
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // new source
   output logic [DATA_W-1:0]   rsp_tdata,
   // divide_error
   output logic                rsp_tuser,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [DATA_W-1:0]   csr_wdata
);

   logic [DATA_W-1:0] inv_eig_ff;
   logic              push_valid;
   logic              push_ready;
   misu_job_type      push_job;
   logic              job_valid;
   logic              job_ready;
   misu_job_type      job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_eig_ff <= DATA_W'(1) << FRAC_BITS;
      end else if (csr_valid && csr_ready) begin
         inv_eig_ff <= csr_wdata;
      end
   end

   misu_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   misu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (job_valid),
      .pop_ready  (job_ready),
      .pop_job    (job)
   );

   misu_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .inverse_eigenvalue (inv_eig_ff),
      .job_valid          (job_valid),
      .job_ready          (job_ready),
      .job                (job),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata),
      .rsp_tuser          (rsp_tuser)
   );

   // a zero total cross section always comes out as the saturated value
   `MISU_ASSERT_IMP(a_err_saturates, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == {DATA_W{1'b1}}, "divide error without saturated source")
   // the finishing unit stays busy after taking a job
   `MISU_ASSERT_NXT(a_back_busy, clock, reset, job_valid && job_ready, !job_ready, "finishing unit took two jobs back to back")
   // a closing request stuck at a full queue holds the front
   `MISU_ASSERT_IMP(a_push_blocks_front, clock, reset, push_valid && !push_ready, !req_tready, "front accepted a request while a job was stuck")

endmodule

@@ rtl/core/misu_front.sv @@
// front end: takes requests, forms products and accumulates the two dot products
module misu_front
   import misu_pkg::*;
#(
   parameter int FRAC_BITS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [5*DATA_W-1:0] req_tdata,
   input  logic               req_tlast,
   output logic               push_valid,
   input  logic               push_ready,
   output misu_job_type       push_job
);

   logic [DATA_W-1:0] sxs;
   logic [DATA_W-1:0] fxs;
   logic [DATA_W-1:0] flux;

   logic              a_valid_ff;
   logic              a_last_ff;
   logic [ACC_W-1:0]  a_ps_ff;
   logic [ACC_W-1:0]  a_pf_ff;
   logic [DATA_W-1:0] a_chi_ff;
   logic [DATA_W-1:0] a_tot_ff;
   logic [ACC_W-1:0]  prod_s;
   logic [ACC_W-1:0]  prod_f;

   logic [ACC_W-1:0]  scat_ff;
   logic [ACC_W-1:0]  fiss_ff;
   logic [ACC_W-1:0]  scat_in;
   logic [ACC_W-1:0]  fiss_in;
   logic              advance;
   logic              accept;

   assign sxs  = req_tdata[DATA_W-1:0];
   assign fxs  = req_tdata[2*DATA_W-1:DATA_W];
   assign flux = req_tdata[3*DATA_W-1:2*DATA_W];

   assign prod_s = ACC_W'(sxs) * ACC_W'(flux);
   assign prod_f = ACC_W'(fxs) * ACC_W'(flux);

   // a last item waits in stage a until the queue has room
   assign advance    = a_valid_ff && (!a_last_ff || push_ready);
   assign req_tready = !a_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign scat_in = sat_add(scat_ff, a_ps_ff);
   assign fiss_in = sat_add(fiss_ff, a_pf_ff);

   assign push_valid                = a_valid_ff && a_last_ff;
   assign push_job.scatter_sum      = scat_in;
   assign push_job.fission_sum      = fiss_in;
   assign push_job.fission_spectrum = a_chi_ff;
   assign push_job.total_xs         = a_tot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         scat_ff    <= '0;
         fiss_ff    <= '0;
      end else begin
         if (accept) begin
            a_valid_ff <= 1'b1;
         end else if (advance) begin
            a_valid_ff <= 1'b0;
         end
         if (advance) begin
            scat_ff <= a_last_ff ? '0 : scat_in;
            fiss_ff <= a_last_ff ? '0 : fiss_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_last_ff <= req_tlast;
         a_ps_ff   <= prod_s >> FRAC_BITS;
         a_pf_ff   <= prod_f >> FRAC_BITS;
         a_chi_ff  <= req_tdata[4*DATA_W-1:3*DATA_W];
         a_tot_ff  <= req_tdata[5*DATA_W-1:4*DATA_W];
      end
   end

endmodule

@@ rtl/core/misu_queue.sv @@
// short job queue between the accumulator and the finishing unit
module misu_queue
   import misu_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  misu_job_type push_job,
   output logic         pop_valid,
   input  logic         pop_ready,
   output misu_job_type pop_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   misu_job_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ rtl/core/misu_back.sv @@
// finishing unit: fission scaling, 1/(4 pi) scaling, divide and result register
module misu_back
   import misu_pkg::*;
#(
   parameter int FRAC_BITS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [DATA_W-1:0] inverse_eigenvalue,
   input  logic              job_valid,
   output logic              job_ready,
   input  misu_job_type      job,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,
   output logic              rsp_tuser
);

   localparam int PROD_W = 2 * ACC_W;

   misu_state_type    state_ff;
   misu_state_type    state_in;
   misu_job_type      job_ff;

   logic [ACC_W-1:0]  chik_ff;
   logic [ACC_W-1:0]  sum_ff;
   logic [PROD_W-1:0] acc_ff;
   logic [ACC_W-1:0]  pp_ff;
   logic [1:0]        pp_sh_ff;
   logic              pp_vld_ff;
   logic [2:0]        step_ff;

   logic [DATA_W-1:0] rem_ff;
   logic [DATA_W-1:0] dvd_ff;
   logic [DATA_W-1:0] quo_ff;
   logic [4:0]        cnt_ff;
   logic              err_ff;

   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_src_ff;
   logic              rsp_err_ff;

   logic              load_out;
   logic [ACC_W-1:0]  mul_a;
   logic [ACC_W-1:0]  mul_b;
   logic [DATA_W-1:0] a_part;
   logic [DATA_W-1:0] b_part;
   logic [PROD_W-1:0] pp_term;
   logic [PROD_W-1:0] acc_fis_sh;
   logic [PROD_W-1:0] acc_scl_sh;
   logic [ACC_W-1:0]  fis_val;
   logic [ACC_W-1:0]  scaled_val;
   logic [ACC_W-1:0]  tot_limit;
   logic [ACC_W-1:0]  dividend;
   logic              tot_zero;
   logic              too_big;
   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   diff;
   logic              ge;

   // shared 32x32 multiplier walks the four partial products of a 64x64 product
   always_comb begin
      if (state_ff == ST_SCALE) begin
         mul_a = sum_ff;
         mul_b = ACC_W'(INV_FOUR_PI_Q32);
      end else begin
         mul_a = job_ff.fission_sum;
         mul_b = chik_ff;
      end
      a_part = step_ff[1] ? mul_a[ACC_W-1:DATA_W] : mul_a[DATA_W-1:0];
      b_part = step_ff[0] ? mul_b[ACC_W-1:DATA_W] : mul_b[DATA_W-1:0];
   end

   always_comb begin
      unique case (pp_sh_ff)
         2'd0:    pp_term = {{ACC_W{1'b0}}, pp_ff};
         2'd1:    pp_term = {{DATA_W{1'b0}}, pp_ff, {DATA_W{1'b0}}};
         2'd2:    pp_term = {pp_ff, {ACC_W{1'b0}}};
         default: pp_term = '0;
      endcase
      if (!pp_vld_ff) begin
         pp_term = '0;
      end
   end

   assign acc_fis_sh = acc_ff >> FRAC_BITS;
   assign acc_scl_sh = acc_ff >> DATA_W;
   assign fis_val    = (|acc_fis_sh[PROD_W-1:ACC_W]) ? {ACC_W{1'b1}} : acc_fis_sh[ACC_W-1:0];
   assign scaled_val = (|acc_scl_sh[PROD_W-1:ACC_W]) ? {ACC_W{1'b1}} : acc_scl_sh[ACC_W-1:0];

   assign tot_zero  = (job_ff.total_xs == '0);
   assign tot_limit = ACC_W'(job_ff.total_xs) << (DATA_W - FRAC_BITS);
   assign too_big   = (scaled_val >= tot_limit);
   // below the limit the shifted value fits 64 bits and the quotient fits 32
   assign dividend  = scaled_val << FRAC_BITS;

   assign trial = {rem_ff, dvd_ff[DATA_W-1]};
   assign diff  = trial - {1'b0, job_ff.total_xs};
   assign ge    = (trial >= {1'b0, job_ff.total_xs});

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (job_valid) state_in = ST_CHI;
         ST_CHI:   state_in = ST_FIS;
         ST_FIS:   if (step_ff[2]) state_in = ST_SUM;
         ST_SUM:   state_in = ST_SCALE;
         ST_SCALE: if (step_ff[2]) state_in = ST_CHECK;
         ST_CHECK: state_in = (tot_zero || too_big) ? ST_DONE : ST_DIV;
         ST_DIV:   if (cnt_ff == '0) state_in = ST_DONE;
         ST_DONE:  if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      job_ready = (state_ff == ST_IDLE);
      load_out  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_ff <= job;
            end
         end
         ST_CHI: begin
            chik_ff   <= (ACC_W'(job_ff.fission_spectrum) * ACC_W'(inverse_eigenvalue))
                         >> FRAC_BITS;
            acc_ff    <= '0;
            step_ff   <= '0;
            pp_vld_ff <= 1'b0;
         end
         ST_FIS, ST_SCALE: begin
            pp_ff     <= ACC_W'(a_part) * ACC_W'(b_part);
            pp_sh_ff  <= {1'b0, step_ff[1]} + {1'b0, step_ff[0]};
            pp_vld_ff <= !step_ff[2];
            step_ff   <= step_ff + 1'b1;
            acc_ff    <= acc_ff + pp_term;
         end
         ST_SUM: begin
            sum_ff    <= sat_add(job_ff.scatter_sum, fis_val);
            acc_ff    <= '0;
            step_ff   <= '0;
            pp_vld_ff <= 1'b0;
         end
         ST_CHECK: begin
            err_ff <= tot_zero;
            quo_ff <= {DATA_W{1'b1}};
            rem_ff <= dividend[ACC_W-1:DATA_W];
            dvd_ff <= dividend[DATA_W-1:0];
            cnt_ff <= 5'd31;
         end
         ST_DIV: begin
            rem_ff <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            dvd_ff <= {dvd_ff[DATA_W-2:0], 1'b0};
            quo_ff <= {quo_ff[DATA_W-2:0], ge};
            cnt_ff <= cnt_ff - 1'b1;
         end
         ST_DONE: begin
            if (load_out) begin
               rsp_src_ff <= quo_ff;
               rsp_err_ff <= err_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_src_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule
